// ===== src/fpur_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpur_pkg
// Shared constants and types for the flash page upload receiver.
// ----------------------------------------------------------------------------
package fpur_pkg;

	// data bytes in one page frame
	localparam int PAGE_BYTES = 128;

	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 16;
	localparam int WORD_W   = 16;
	localparam int IDLE_W   = 24;
	localparam int ACTION_W = 2;

	localparam logic [BYTE_W-1:0]   PAGE_BYTES_B  = BYTE_W'(PAGE_BYTES);
	localparam logic [IDLE_W-1:0]   IDLE_MAX      = {IDLE_W{1'b1}};
	localparam logic [IDLE_W-1:0]   IDLE_LIMIT_RST = IDLE_W'(1000000);

	localparam logic [BYTE_W-1:0] CH_START  = 8'h40; // '@'
	localparam logic [BYTE_W-1:0] CH_REBOOT = 8'h2d; // '-'
	localparam logic [BYTE_W-1:0] CH_OK     = 8'h2e; // '.'
	localparam logic [BYTE_W-1:0] CH_ERR    = 8'h21; // '!'
	localparam logic [BYTE_W-1:0] CH_NONE   = 8'h00;

	typedef enum logic [0:0] {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_FILL   = 2'd0,
		ACT_COMMIT = 2'd1,
		ACT_ERROR  = 2'd2,
		ACT_REBOOT = 2'd3
	} action_t;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_PAGE  = 5'b00010,
		PH_DATA  = 5'b00100,
		PH_CKSUM = 5'b01000,
		PH_HALT  = 5'b10000
	} phase_t;

endpackage

// ===== src/flash_page_upload_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_page_upload_receiver
// Frame decoder for serial page uploads into flash: fill, commit and reboot.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_stall, op, rx_byte): one beat per received
//   byte (op 0) or idle tick (op 1). Result channel (result_valid/
//   result_stall, action, flash_address, flash_word, reply_char): zero or one
//   beat per item; fill words, commit/error at the end of a page, reboot.
//   Config channel (cfg_valid/cfg_ready, idle_limit): writes the idle tick
//   limit, always ready; write only while no item is in flight.
//   An item is registered on acceptance, decoded, and its result is then
//   registered in the output register, from which it is shown. Throughput
//   is one item per cycle while no pending result is stalled, set by the
//   single decode step between the input register and the output register.
//   When the receiver stalls, the result holds; one more item may be taken
//   into the input register, then item_stall rises until the result leaves.
//   Reset clears the frame state, idle counter and the valid flags of both
//   registers and sets the idle limit to 1000000. After a reboot result the
//   block swallows all further items without results until reset.
// ----------------------------------------------------------------------------
module flash_page_upload_receiver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fpur_pkg::IDLE_W-1:0]       idle_limit,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic                              op,
	input  logic [fpur_pkg::BYTE_W-1:0]       rx_byte,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [fpur_pkg::ACTION_W-1:0]     action,
	output logic [fpur_pkg::ADDR_W-1:0]       flash_address,
	output logic [fpur_pkg::WORD_W-1:0]       flash_word,
	output logic [fpur_pkg::BYTE_W-1:0]       reply_char
);

	// input register
	logic                          valid_s1;
	logic                          op_s1;
	logic [fpur_pkg::BYTE_W-1:0]   byte_s1;

	// frame state
	fpur_pkg::phase_t              phase_q, phase_d;
	logic [fpur_pkg::BYTE_W-1:0]   byte_count_q, byte_count_d;
	logic [fpur_pkg::BYTE_W-1:0]   running_sum_q, running_sum_d;
	logic [fpur_pkg::ADDR_W-1:0]   page_base_q, page_base_d;
	logic [fpur_pkg::BYTE_W-1:0]   low_byte_q, low_byte_d;
	logic [fpur_pkg::IDLE_W-1:0]   idle_count_q, idle_count_d;
	logic [fpur_pkg::IDLE_W-1:0]   idle_limit_q;

	// output register
	logic                          out_valid_q;
	fpur_pkg::action_t             action_q;
	logic [fpur_pkg::ADDR_W-1:0]   address_q;
	logic [fpur_pkg::WORD_W-1:0]   word_q;
	logic [fpur_pkg::BYTE_W-1:0]   reply_q;

	logic                          advance;
	logic                          proc;
	logic                          accept;
	logic                          res_valid;
	fpur_pkg::action_t             res_action;
	logic [fpur_pkg::ADDR_W-1:0]   res_address;
	logic [fpur_pkg::WORD_W-1:0]   res_word;
	logic [fpur_pkg::BYTE_W-1:0]   res_reply;
	logic [fpur_pkg::BYTE_W-1:0]   count_inc;
	logic [fpur_pkg::IDLE_W-1:0]   page_prod;
	logic [fpur_pkg::ADDR_W-1:0]   fill_addr;

	assign advance    = !out_valid_q || !result_stall;
	assign proc       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign count_inc = byte_count_q + 8'd1;
	assign page_prod = {{(fpur_pkg::IDLE_W - fpur_pkg::BYTE_W){1'b0}}, byte_s1}
		* fpur_pkg::IDLE_W'(fpur_pkg::PAGE_BYTES);
	// count is odd on the high byte, so count - 1 just drops bit 0
	assign fill_addr = page_base_q
		+ {{(fpur_pkg::ADDR_W - fpur_pkg::BYTE_W){1'b0}}, byte_count_q[7:1], 1'b0};

	always_comb begin
		phase_d       = phase_q;
		byte_count_d  = byte_count_q;
		running_sum_d = running_sum_q;
		page_base_d   = page_base_q;
		low_byte_d    = low_byte_q;
		idle_count_d  = idle_count_q;
		res_valid     = 1'b0;
		res_action    = fpur_pkg::ACT_FILL;
		res_address   = '0;
		res_word      = '0;
		res_reply     = fpur_pkg::CH_NONE;
		if (phase_q != fpur_pkg::PH_HALT) begin
			if (op_s1 == fpur_pkg::OP_TICK) begin
				if (idle_count_q > idle_limit_q) begin
					phase_d    = fpur_pkg::PH_HALT;
					res_valid  = 1'b1;
					res_action = fpur_pkg::ACT_REBOOT;
				end else if (idle_count_q != fpur_pkg::IDLE_MAX) begin
					idle_count_d = idle_count_q + 24'd1;
				end
			end else begin
				idle_count_d = '0;
				case (phase_q)
					fpur_pkg::PH_PAGE: begin
						byte_count_d  = '0;
						running_sum_d = byte_s1;
						page_base_d   = page_prod[fpur_pkg::ADDR_W-1:0];
						phase_d       = fpur_pkg::PH_DATA;
					end
					fpur_pkg::PH_DATA: begin
						running_sum_d = running_sum_q + byte_s1;
						if (byte_count_q[0]) begin
							res_valid   = 1'b1;
							res_action  = fpur_pkg::ACT_FILL;
							res_address = fill_addr;
							res_word    = {byte_s1, low_byte_q};
						end else begin
							low_byte_d = byte_s1;
						end
						byte_count_d = count_inc;
						if (count_inc == fpur_pkg::PAGE_BYTES_B) begin
							phase_d = fpur_pkg::PH_CKSUM;
						end
					end
					fpur_pkg::PH_CKSUM: begin
						phase_d     = fpur_pkg::PH_IDLE;
						res_valid   = 1'b1;
						res_address = page_base_q;
						if (running_sum_q == byte_s1) begin
							res_action = fpur_pkg::ACT_COMMIT;
							res_reply  = fpur_pkg::CH_OK;
						end else begin
							res_action = fpur_pkg::ACT_ERROR;
							res_reply  = fpur_pkg::CH_ERR;
						end
					end
					default: begin
						if (byte_s1 == fpur_pkg::CH_START) begin
							phase_d = fpur_pkg::PH_PAGE;
						end else if (byte_s1 == fpur_pkg::CH_REBOOT) begin
							phase_d    = fpur_pkg::PH_HALT;
							res_valid  = 1'b1;
							res_action = fpur_pkg::ACT_REBOOT;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= fpur_pkg::IDLE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			idle_limit_q <= idle_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= fpur_pkg::PH_IDLE;
			byte_count_q  <= '0;
			running_sum_q <= '0;
			page_base_q   <= '0;
			low_byte_q    <= '0;
			idle_count_q  <= '0;
		end else if (proc) begin
			phase_q       <= phase_d;
			byte_count_q  <= byte_count_d;
			running_sum_q <= running_sum_d;
			page_base_q   <= page_base_d;
			low_byte_q    <= low_byte_d;
			idle_count_q  <= idle_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= proc && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			action_q  <= res_action;
			address_q <= res_address;
			word_q    <= res_word;
			reply_q   <= res_reply;
		end
	end

	assign result_valid  = out_valid_q;
	assign action        = action_q;
	assign flash_address = address_q;
	assign flash_word    = word_q;
	assign reply_char    = reply_q;

`ifndef ASSERT_OFF
	// once halted, the block stays halted until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == fpur_pkg::PH_HALT |=> phase_q == fpur_pkg::PH_HALT)
		else $error("left halted phase without reset");

	// a reboot beat always lands the block in the halted phase
	a_reboot_halts: assert property (@(posedge clk) disable iff (!arst_n)
		proc && res_valid && res_action == fpur_pkg::ACT_REBOOT
		|=> phase_q == fpur_pkg::PH_HALT)
		else $error("reboot result without halt");

	// a held item is never dropped while the output side is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(op_s1))
		else $error("input register lost a held item");

	// the data byte count never runs past a page
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= fpur_pkg::PAGE_BYTES_B)
		else $error("byte count past page size");
`endif

endmodule

// ===== verif/flash_page_upload_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_page_upload_receiver_tb
// Self-checking bench for the page upload receiver. A short table of directed
// frames is followed by a few hundred random beats, mostly well-formed frames
// with idle ticks and stray bytes mixed in. An in-bench decoder predicts every
// fill, commit, error and reboot beat. The idle limit is rewritten between
// phases, and both channels idle at random. The run ends in a single reboot,
// after which the block must swallow everything.
// ----------------------------------------------------------------------------
module flash_page_upload_receiver_tb;

	localparam int RANDOM_ITEMS = 450;
	localparam int HOLD_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		fpur_pkg::action_t                 act;
		logic [fpur_pkg::ADDR_W-1:0]       addr;
		logic [fpur_pkg::WORD_W-1:0]       word;
		logic [fpur_pkg::BYTE_W-1:0]       ch;
	} flash_action_t;

	typedef enum {ROW_PREDICT, ROW_FIXED, ROW_CHECKSUM} row_kind_t;

	typedef struct {
		row_kind_t                         kind;
		fpur_pkg::op_t                     k;
		logic [fpur_pkg::BYTE_W-1:0]       b;
		int                                reps;
		bit                                has;
		flash_action_t                     r;
	} plan_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [fpur_pkg::IDLE_W-1:0]         idle_limit;
	logic                                item_valid;
	logic                                item_stall;
	logic                                op;
	logic [fpur_pkg::BYTE_W-1:0]         rx_byte;
	logic                                result_valid;
	logic                                result_stall;
	logic [fpur_pkg::ACTION_W-1:0]       action;
	logic [fpur_pkg::ADDR_W-1:0]         flash_address;
	logic [fpur_pkg::WORD_W-1:0]         flash_word;
	logic [fpur_pkg::BYTE_W-1:0]         reply_char;

	flash_page_upload_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.idle_limit    (idle_limit),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.op            (op),
		.rx_byte       (rx_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.action        (action),
		.flash_address (flash_address),
		.flash_word    (flash_word),
		.reply_char    (reply_char)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder copy of the frame state
	fpur_pkg::phase_t              ph        = fpur_pkg::PH_IDLE;
	logic [fpur_pkg::BYTE_W-1:0]   byte_cnt  = '0;
	logic [fpur_pkg::BYTE_W-1:0]   run_sum   = '0;
	logic [fpur_pkg::ADDR_W-1:0]   page_base = '0;
	logic [fpur_pkg::BYTE_W-1:0]   low_hold  = '0;
	logic [fpur_pkg::IDLE_W-1:0]   idle_cnt  = '0;
	logic [fpur_pkg::IDLE_W-1:0]   limit_cfg = fpur_pkg::IDLE_LIMIT_RST;

	flash_action_t queued_actions[$];
	int  failures = 0;
	int  items_sent = 0;
	int  results_checked = 0;
	int  cfg_writes = 0;
	int  cycles = 0;
	bit  hold_req = 1'b0;

	function automatic bit decode_upload(input fpur_pkg::op_t k,
			input logic [fpur_pkg::BYTE_W-1:0] b, output flash_action_t r);
		bit has;
		has = 1'b0;
		r = '{fpur_pkg::ACT_FILL, '0, '0, fpur_pkg::CH_NONE};
		if (ph == fpur_pkg::PH_HALT)
			return 1'b0;
		if (k == fpur_pkg::OP_TICK) begin
			if (idle_cnt > limit_cfg) begin
				ph = fpur_pkg::PH_HALT;
				r.act = fpur_pkg::ACT_REBOOT;
				return 1'b1;
			end
			if (idle_cnt != fpur_pkg::IDLE_MAX)
				idle_cnt = idle_cnt + 1'b1;
			return 1'b0;
		end
		idle_cnt = '0;
		case (ph)
			fpur_pkg::PH_PAGE: begin
				byte_cnt  = '0;
				run_sum   = b;
				page_base = fpur_pkg::ADDR_W'(32'(b) * fpur_pkg::PAGE_BYTES);
				ph        = fpur_pkg::PH_DATA;
			end
			fpur_pkg::PH_DATA: begin
				run_sum = run_sum + b;
				if (byte_cnt[0]) begin
					r.addr = page_base + fpur_pkg::ADDR_W'(byte_cnt) - 1'b1;
					r.word = {b, low_hold};
					has    = 1'b1;
				end else begin
					low_hold = b;
				end
				byte_cnt = byte_cnt + 1'b1;
				if (byte_cnt == fpur_pkg::PAGE_BYTES_B)
					ph = fpur_pkg::PH_CKSUM;
			end
			fpur_pkg::PH_CKSUM: begin
				ph     = fpur_pkg::PH_IDLE;
				r.addr = page_base;
				has    = 1'b1;
				if (run_sum == b) begin
					r.act = fpur_pkg::ACT_COMMIT;
					r.ch  = fpur_pkg::CH_OK;
				end else begin
					r.act = fpur_pkg::ACT_ERROR;
					r.ch  = fpur_pkg::CH_ERR;
				end
			end
			default: begin
				if (b == fpur_pkg::CH_START) begin
					ph = fpur_pkg::PH_PAGE;
				end else if (b == fpur_pkg::CH_REBOOT) begin
					ph    = fpur_pkg::PH_HALT;
					r.act = fpur_pkg::ACT_REBOOT;
					has   = 1'b1;
				end
			end
		endcase
		return has;
	endfunction

	// mostly back to back or short, now and then a long gap
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic plan_row_t plan_row(input row_kind_t kind, input fpur_pkg::op_t k,
			input logic [fpur_pkg::BYTE_W-1:0] b, input int reps, input bit has,
			input fpur_pkg::action_t act, input logic [fpur_pkg::ADDR_W-1:0] addr,
			input logic [fpur_pkg::BYTE_W-1:0] ch);
		plan_row_t row;
		row.kind = kind;
		row.k    = k;
		row.b    = b;
		row.reps = reps;
		row.has  = has;
		row.r    = '{act, addr, '0, ch};
		return row;
	endfunction

	task automatic push_item(input fpur_pkg::op_t k, input logic [fpur_pkg::BYTE_W-1:0] b,
			output bit has, output flash_action_t r);
		item_valid <= 1'b1;
		op         <= k;
		rx_byte    <= b;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		has = decode_upload(k, b, r);
		items_sent++;
	endtask

	task automatic pace_sender();
		int n;
		n = hold_req ? 0 : gap_len();
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic offer(input fpur_pkg::op_t k, input logic [fpur_pkg::BYTE_W-1:0] b);
		bit has;
		flash_action_t r;
		push_item(k, b, has, r);
		if (has)
			queued_actions.push_back(r);
		pace_sender();
	endtask

	// drain everything in flight, then write the limit
	task automatic set_idle_limit(input logic [fpur_pkg::IDLE_W-1:0] v);
		item_valid <= 1'b0;
		while (queued_actions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid  <= 1'b1;
		idle_limit <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		limit_cfg = v;
		cfg_writes++;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		flash_action_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (queued_actions.size() == 0) begin
				$error("result beat with nothing pending: action %0d address %h",
					action, flash_address);
				failures++;
			end else begin
				want = queued_actions.pop_front();
				results_checked++;
				if (action !== want.act) begin
					$error("action: expected %0d, got %0d", want.act, action);
					failures++;
				end
				if (flash_address !== want.addr) begin
					$error("flash_address: expected %h, got %h", want.addr, flash_address);
					failures++;
				end
				if (flash_word !== want.word) begin
					$error("flash_word: expected %h, got %h", want.word, flash_word);
					failures++;
				end
				if (reply_char !== want.ch) begin
					$error("reply_char: expected %h, got %h", want.ch, reply_char);
					failures++;
				end
			end
		end
	end

	// result side: random stalls, quiet stretches and one long hold-off
	initial begin
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				result_stall <= 1'b0;
				repeat (60) @(posedge clk);
			end else if ($urandom_range(0, 1) == 1) begin
				result_stall <= 1'b1;
				repeat (1 + gap_len()) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin
		plan_row_t plan[$];
		logic [fpur_pkg::IDLE_W-1:0] limit_plan[5];
		logic [fpur_pkg::BYTE_W-1:0] b;
		fpur_pkg::op_t k;
		bit has;
		bit by_timeout;
		flash_action_t r;
		int step;

		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		idle_limit <= '0;
		item_valid <= 1'b0;
		op         <= fpur_pkg::OP_BYTE;
		rx_byte    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray beats at idle, an all-zero page, an all-ones page with a bad sum,
		// then a frame with ticks inside and marker bytes used as page and data
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_TICK, 8'h5a, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_BYTE, 8'h00, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_BYTE, 8'hff, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_BYTE, fpur_pkg::CH_OK, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_BYTE, fpur_pkg::CH_START, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_BYTE, 8'h00, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_PREDICT, fpur_pkg::OP_BYTE, 8'h00, fpur_pkg::PAGE_BYTES,
			1'b0, fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_BYTE, 8'h00, 1, 1'b1,
			fpur_pkg::ACT_COMMIT, '0, fpur_pkg::CH_OK));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_BYTE, fpur_pkg::CH_START, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_BYTE, 8'hff, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_PREDICT, fpur_pkg::OP_BYTE, 8'hff, fpur_pkg::PAGE_BYTES,
			1'b0, fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_BYTE, 8'h00, 1, 1'b1,
			fpur_pkg::ACT_ERROR, 16'h7f80, fpur_pkg::CH_ERR));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_BYTE, fpur_pkg::CH_START, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_TICK, 8'ha5, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_BYTE, fpur_pkg::CH_START, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_PREDICT, fpur_pkg::OP_BYTE, fpur_pkg::CH_REBOOT, 2, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_TICK, 8'hff, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_PREDICT, fpur_pkg::OP_BYTE, 8'ha5,
			fpur_pkg::PAGE_BYTES - 3, 1'b0, fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_FIXED, fpur_pkg::OP_TICK, 8'h00, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_PREDICT, fpur_pkg::OP_BYTE, 8'h5a, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));
		plan.push_back(plan_row(ROW_CHECKSUM, fpur_pkg::OP_BYTE, 8'h00, 1, 1'b0,
			fpur_pkg::ACT_FILL, '0, fpur_pkg::CH_NONE));

		foreach (plan[i]) begin
			for (int rep = 0; rep < plan[i].reps; rep++) begin
				b = (plan[i].kind == ROW_CHECKSUM) ? run_sum : plan[i].b;
				push_item(plan[i].k, b, has, r);
				if (plan[i].kind == ROW_FIXED) begin
					has = plan[i].has;
					r   = plan[i].r;
				end
				if (has)
					queued_actions.push_back(r);
				pace_sender();
			end
		end

		limit_plan[0] = '0;
		limit_plan[1] = fpur_pkg::IDLE_MAX;
		limit_plan[2] = fpur_pkg::IDLE_W'($urandom);
		limit_plan[3] = fpur_pkg::IDLE_W'(1);
		limit_plan[4] = fpur_pkg::IDLE_W'($urandom_range(2, 20));

		// random frames; ticks are held back where they would time out
		for (step = 0; step < RANDOM_ITEMS; step++) begin
			if (step % 90 == 0 && step / 90 < 5)
				set_idle_limit(limit_plan[step / 90]);
			if (step == 280)
				hold_req = 1'b1;
			if ($urandom_range(0, 99) < 8 && idle_cnt <= limit_cfg) begin
				k = fpur_pkg::OP_TICK;
				b = fpur_pkg::BYTE_W'($urandom);
			end else begin
				k = fpur_pkg::OP_BYTE;
				b = fpur_pkg::BYTE_W'($urandom);
				if (ph == fpur_pkg::PH_IDLE) begin
					if ($urandom_range(0, 9) < 7)
						b = fpur_pkg::CH_START;
					else if (b == fpur_pkg::CH_REBOOT)
						b = b ^ 8'h01;
				end else if (ph == fpur_pkg::PH_CKSUM && $urandom_range(0, 9) < 7) begin
					b = run_sum;
				end
			end
			offer(k, b);
		end

		// one reboot closes the run, either by timeout or by the reboot byte
		by_timeout = 1'($urandom_range(0, 1));
		if (by_timeout) begin
			set_idle_limit(fpur_pkg::IDLE_W'($urandom_range(0, 3)));
			while (ph != fpur_pkg::PH_HALT)
				offer(fpur_pkg::OP_TICK, fpur_pkg::BYTE_W'($urandom));
		end else begin
			while (ph != fpur_pkg::PH_IDLE)
				offer(fpur_pkg::OP_BYTE, fpur_pkg::BYTE_W'($urandom));
			offer(fpur_pkg::OP_BYTE, fpur_pkg::CH_REBOOT);
		end
		// halted: nothing may come out any more
		for (step = 0; step < 12; step++)
			offer(fpur_pkg::op_t'($urandom_range(0, 1)),
				(step % 3 == 0) ? fpur_pkg::CH_START : fpur_pkg::BYTE_W'($urandom));

		item_valid <= 1'b0;
		while (queued_actions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d beats sent, %0d result beats checked, %0d idle limit writes",
			items_sent, results_checked, cfg_writes);
		$display("closing reboot by %s, followed by ignored beats",
			by_timeout ? "idle timeout" : "reboot byte");
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
